/* hdl/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by the allocator top level.
package ffba_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 65536;
  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 8;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned REQ_W  = 17;
  localparam int unsigned STAT_W = 2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMEM    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_address;
  } req_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [STAT_W-1:0] status;
  } rsp_item_t;

endpackage

/* hdl/first_fit_block_allocator.sv */
// First-fit heap allocator without splitting; block table in ffba_ram, needs ffba_pkg.
// S_SCAN reads the table, one entry per cycle through the single read port, up to a hit;
// with no hit (or an empty table) S_MISS appends a block or reports a miss.
// busy drops with the result strobe; a new item is accepted only while idle.
// Reset (synchronous, rst_n low): block count, break and heap base cleared,
// no table clearing pass. Results are strobed once and cannot be stalled.
module first_fit_block_allocator #(
  parameter int unsigned HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffba_pkg::req_item_t in_item,
  output logic                out_valid,
  output ffba_pkg::rsp_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  import ffba_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned START_W = $clog2(HEAP_BYTES);
  localparam int unsigned SIZE_W  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned BRK_W   = SIZE_W;
  localparam int unsigned NEED_W  = REQ_W + 1;
  localparam int unsigned CMP_W   = (SIZE_W > NEED_W) ? SIZE_W : NEED_W;
  localparam int unsigned SUM_W   = CMP_W + 1;
  localparam int unsigned ENT_W   = START_W + SIZE_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MISS
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BRK_W-1:0]  brk_r, brk_nxt;
  logic [ADDR_W-1:0] base_hdr_r, base_hdr_nxt;
  logic              op_r, op_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [ADDR_W-1:0] target_r, target_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_item_t         out_item_r, out_item_nxt;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [ENT_W-1:0]  wr_data, rd_data;

  logic [START_W-1:0] ent_start;
  logic [SIZE_W-1:0]  ent_size;
  logic               ent_free;
  logic               fit, match, hit, last, full, overflow;
  logic [SUM_W-1:0]   brk_sum;

  ffba_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign ent_start = rd_data[ENT_W-1 -: START_W];
  assign ent_size  = rd_data[SIZE_W:1];
  assign ent_free  = rd_data[0];

  assign fit   = ent_free && (CMP_W'(ent_size) >= CMP_W'(need_r));
  assign match = (ADDR_W'(ent_start) == target_r);
  assign hit   = (op_r == REQ_ALLOC) ? fit : match;
  assign last  = ((CNT_W'(idx_r) + CNT_W'(1)) >= count_r);
  assign full  = (count_r == CNT_W'(MAX_BLOCKS));
  assign brk_sum  = SUM_W'(brk_r) + SUM_W'(need_r);
  assign overflow = (brk_sum > SUM_W'(HEAP_BYTES));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    brk_nxt       = brk_r;
    base_hdr_nxt  = base_hdr_r;
    op_nxt        = op_r;
    need_nxt      = need_r;
    target_nxt    = target_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_en         = 1'b0;
    rd_addr       = IDX_W'(CNT_W'(idx_r) + CNT_W'(1));
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = {ent_start, ent_size, (op_r == REQ_FREE)};

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          base_hdr_nxt = cfg_data + ADDR_W'(HEADER_BYTES);
        end
        if (start) begin
          op_nxt     = in_item.req_type;
          need_nxt   = NEED_W'(in_item.request_bytes) + NEED_W'(HEADER_BYTES);
          target_nxt = in_item.free_address - base_hdr_r;
          idx_nxt    = '0;
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_nxt  = (count_r == '0) ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (hit) begin
          wr_en         = 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt.status  = STAT_OK;
          out_item_nxt.address = (op_r == REQ_ALLOC) ?
                                 (base_hdr_r + ADDR_W'(ent_start)) : '0;
          state_nxt     = S_IDLE;
        end else if (last) begin
          state_nxt = S_MISS;
        end else begin
          idx_nxt = IDX_W'(CNT_W'(idx_r) + CNT_W'(1));
        end
      end
      S_MISS: begin
        out_valid_nxt        = 1'b1;
        out_item_nxt.address = '0;
        state_nxt            = S_IDLE;
        if (op_r == REQ_FREE) begin
          out_item_nxt.status = STAT_BAD_FREE;
        end else if (full || overflow) begin
          out_item_nxt.status = STAT_NOMEM;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = count_r[IDX_W-1:0];
          wr_data   = {START_W'(brk_r), SIZE_W'(need_r), 1'b0};
          count_nxt = count_r + CNT_W'(1);
          brk_nxt   = BRK_W'(brk_sum);
          out_item_nxt.status  = STAT_OK;
          out_item_nxt.address = base_hdr_r + ADDR_W'(brk_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      brk_r       <= '0;
      base_hdr_r  <= ADDR_W'(HEADER_BYTES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      brk_r       <= brk_nxt;
      base_hdr_r  <= base_hdr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    need_r     <= need_nxt;
    target_r   <= target_nxt;
    out_item_r <= out_item_nxt;
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(MAX_BLOCKS)) && (brk_r <= BRK_W'(HEAP_BYTES)))
    else $error("block count or break out of range");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == STAT_OK || out_item.status == STAT_NOMEM ||
                   out_item.status == STAT_BAD_FREE))
    else $error("undefined status code");

endmodule

/* hdl/ffba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the allocator block table.
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
